[rtl/ssnf_pkg.sv]
// Shared types and constants for the seven-segment number formatter.
// Used by ssnf_digit_sr, seven_segment_number_formatter and the testbench; no dependencies.
package ssnf_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 8;
  localparam int unsigned BIN_W           = 32;
  localparam int unsigned BCD_DIGITS      = 10;
  localparam int unsigned BCD_W           = 4 * BCD_DIGITS;
  localparam int unsigned POS_W           = 4;

  localparam logic [4:0] GLYPH_BLANK = 5'd16;
  localparam logic [4:0] GLYPH_MINUS = 5'd17;
  localparam logic [4:0] GLYPH_BAD   = 5'd18;

  typedef struct packed {
    logic              kind;
    logic [3:0]        first_position;
    logic [3:0]        field_width;
    logic signed [31:0] number;
    logic [3:0]        fraction_digits;
  } cmd_t;

  typedef struct packed {
    logic [2:0] position;
    logic [4:0] glyph;
    logic       point;
    logic       merged_minus;
    logic       last;
  } res_t;

  typedef struct packed {
    logic load_dec;
    logic load_hex;
    logic pop;
  } dsr_ctrl_t;

  typedef struct packed {
    logic       conv_done;
    logic [3:0] digit;
    logic       upper_zero;
  } dsr_stat_t;

endpackage

[rtl/ssnf_digit_sr.sv]
// Digit shift register: serial binary-to-BCD conversion, one bit per cycle
// unless a load or pop wins; low-end nibble readout. Depends on ssnf_pkg.
module ssnf_digit_sr (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ssnf_pkg::dsr_ctrl_t      ctrl_i,
  input  logic [ssnf_pkg::BIN_W-1:0] value_i,
  output ssnf_pkg::dsr_stat_t      stat_o
);
  import ssnf_pkg::*;

  logic [BIN_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [BCD_W-1:0] adj;
  logic [5:0]       cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctrl_i.load_dec) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = 6'(BIN_W);
      run_d = 1'b1;
    end else if (ctrl_i.load_hex) begin
      bcd_d = BCD_W'(value_i);
    end else if (ctrl_i.pop) begin
      bcd_d = bcd_q >> 4;
    end else if (run_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[BIN_W-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.conv_done  = done_q;
  assign stat_o.digit      = bcd_q[3:0];
  assign stat_o.upper_zero = (bcd_q[BCD_W-1:4] == '0);

endmodule

[rtl/seven_segment_number_formatter.sv]
// Top level of the seven-segment number formatter: command capture, write
// sequencer and result register. Depends on ssnf_pkg and ssnf_digit_sr.
//
//   channel   ports                         transfer
//   command   start, cmd_i, busy            start high while busy low
//   result    result_valid_o, result_o      result_valid_o high, one cycle
//
// Decimal: capture, conversion of the magnitude one bit at a time, handoff,
// then one write per cycle. Hex: capture, then the writes of the field; bad
// field: capture, then the writes. Results are registered.
// Reset clears the sequencer and the result strobe. Results cannot be held.
module seven_segment_number_formatter #(
  parameter int unsigned DigitCount = ssnf_pkg::DIGIT_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  ssnf_pkg::cmd_t cmd_i,
  output logic           busy,
  output logic           result_valid_o,
  output ssnf_pkg::res_t result_o
);
  import ssnf_pkg::*;

  localparam logic [4:0]       DcW     = 5'(DigitCount);
  localparam logic [POS_W-1:0] LastPos = POS_W'(DigitCount - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_DIGIT = 6'b000100,
    S_SIGN  = 6'b001000,
    S_BLANK = 6'b010000,
    S_BAD   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] cur_q, cur_d;
  logic [3:0]       idx_q, idx_d;
  logic [3:0]       first_q, frac_q;
  logic             kind_q, neg_q;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;
  dsr_ctrl_t        dsr_ctrl;
  dsr_stat_t        dsr_stat;
  logic [BIN_W-1:0] raw, mag, sr_value;
  logic [4:0]       span;
  logic [POS_W-1:0] cur_dec;
  logic             accept;

  assign raw      = cmd_i.number;
  assign mag      = raw[BIN_W-1] ? (~raw) + BIN_W'(1) : raw;
  assign sr_value = cmd_i.kind ? raw : mag;
  assign span     = {1'b0, cmd_i.first_position} + {1'b0, cmd_i.field_width};
  assign cur_dec  = cur_q - POS_W'(1);
  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);

  ssnf_digit_sr u_digit_sr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dsr_ctrl),
    .value_i(sr_value),
    .stat_o (dsr_stat)
  );

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    dsr_ctrl    = '0;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.position = cur_q[2:0];
    unique case (state_q)
      S_IDLE: begin
        if (start && cmd_i.field_width != 4'd0) begin
          idx_d = '0;
          if (span > DcW) begin
            if ({1'b0, cmd_i.first_position} < DcW) begin
              cur_d   = cmd_i.first_position;
              state_d = S_BAD;
            end
          end else begin
            cur_d = POS_W'(span - 5'd1);
            if (cmd_i.kind) begin
              dsr_ctrl.load_hex = 1'b1;
              state_d           = S_DIGIT;
            end else begin
              dsr_ctrl.load_dec = 1'b1;
              state_d           = S_CONV;
            end
          end
        end
      end
      S_CONV: begin
        if (dsr_stat.conv_done) begin
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        res_valid_d = 1'b1;
        res_d.glyph = {1'b0, dsr_stat.digit};
        if (!kind_q) begin
          res_d.point        = (frac_q != 4'd0) && (idx_q == frac_q);
          res_d.merged_minus = neg_q && (idx_q != 4'd0) && dsr_stat.upper_zero
                               && (dsr_stat.digit == 4'd1) && (cur_q == first_q);
        end
        if (cur_q == first_q) begin
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end else if (kind_q || !dsr_stat.upper_zero) begin
          dsr_ctrl.pop = 1'b1;
          cur_d        = cur_dec;
          idx_d        = idx_q + 4'd1;
        end else begin
          state_d = neg_q ? S_SIGN : S_BLANK;
        end
      end
      S_SIGN, S_BLANK: begin
        res_valid_d    = 1'b1;
        res_d.position = cur_dec[2:0];
        res_d.glyph    = (state_q == S_SIGN) ? GLYPH_MINUS : GLYPH_BLANK;
        cur_d          = cur_dec;
        if (cur_dec == first_q) begin
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_BLANK;
        end
      end
      S_BAD: begin
        res_valid_d = 1'b1;
        res_d.glyph = GLYPH_BAD;
        cur_d       = cur_q + POS_W'(1);
        if (cur_q == LastPos) begin
          res_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    res_q <= res_d;
    if (accept) begin
      first_q <= cmd_i.first_position;
      frac_q  <= cmd_i.fraction_digits;
      kind_q  <= cmd_i.kind;
      neg_q   <= raw[BIN_W-1];
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

[test/ssnf_display_checker.sv]
`timescale 1ns / 1ps
// Checker for the seven-segment number formatter: predicts the digit writes of
// every accepted command and compares each result transfer against them.
// Depends on ssnf_pkg.
module ssnf_display_checker
  import ssnf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  input  logic busy,
  input  logic result_valid_i,
  input  res_t result_i,
  output int   mismatch_count_o,
  output int   pending_writes_o,
  output int   writes_checked_o
);

  localparam int unsigned DIGITS = DIGIT_COUNT_DEF;

  res_t expected_writes_q [$];
  res_t oldest_write;
  int   mismatches     = 0;
  int   writes_checked = 0;

  function automatic res_t make_write(int unsigned pos, logic [4:0] glyph, logic pt,
                                      logic mm);
    res_t w;
    w.position     = 3'(pos);
    w.glyph        = glyph;
    w.point        = pt;
    w.merged_minus = mm;
    w.last         = 1'b0;
    return w;
  endfunction

  function automatic void predict_digit_writes(cmd_t c);
    res_t        w [DIGITS];
    int unsigned n;
    int unsigned i;
    int unsigned first;
    int unsigned width;
    int unsigned frac;
    int unsigned right;
    int unsigned cur;
    logic [31:0] raw;
    logic [31:0] mag;
    logic [3:0]  d;
    logic        neg;
    n     = 0;
    first = c.first_position;
    width = c.field_width;
    frac  = c.fraction_digits;
    raw   = c.number;
    if (width == 0) return;
    if (first + width > DIGITS) begin
      for (i = first; i < DIGITS; i++) begin
        w[n] = make_write(i, GLYPH_BAD, 1'b0, 1'b0);
        n++;
      end
    end else if (c.kind == 1'b0) begin
      neg   = raw[31];
      mag   = neg ? (32'd0 - raw) : raw;
      right = first + width - 1;
      cur   = right;
      w[n]  = make_write(cur, 5'(mag % 10), 1'b0, 1'b0);
      n++;
      while (cur > first) begin
        mag = mag / 10;
        if (mag == 0) break;
        cur--;
        d    = 4'(mag % 10);
        w[n] = make_write(cur, {1'b0, d}, (frac != 0) && (cur + frac == right),
                          neg && (mag < 10) && (d == 4'd1) && (cur == first));
        n++;
      end
      if (cur != first) begin
        if (neg) begin
          cur--;
          w[n] = make_write(cur, GLYPH_MINUS, 1'b0, 1'b0);
          n++;
        end
        while (cur > first) begin
          cur--;
          w[n] = make_write(cur, GLYPH_BLANK, 1'b0, 1'b0);
          n++;
        end
      end
    end else begin
      cur = first + width;
      do begin
        cur--;
        w[n] = make_write(cur, {1'b0, raw[3:0]}, 1'b0, 1'b0);
        n++;
        raw = raw >> 4;
      end while (cur > first);
    end
    if (n > 0) w[n-1].last = 1'b1;
    for (i = 0; i < n; i++) expected_writes_q.push_back(w[i]);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_digit_writes(cmd_i);
      if (result_valid_i) begin
        if (expected_writes_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected write: expected none, actual %p", $time, result_i);
        end else begin
          oldest_write = expected_writes_q.pop_front();
          check_field("position", oldest_write.position, result_i.position);
          check_field("glyph", oldest_write.glyph, result_i.glyph);
          check_field("point", oldest_write.point, result_i.point);
          check_field("merged_minus", oldest_write.merged_minus, result_i.merged_minus);
          check_field("last", oldest_write.last, result_i.last);
          writes_checked++;
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_writes_o <= expected_writes_q.size();
    writes_checked_o <= writes_checked;
  end

endmodule

[test/tb_seven_segment_number_formatter.sv]
`timescale 1ns / 1ps
// Testbench top for the seven-segment number formatter: clock, reset, command
// stimulus and verdict. Depends on ssnf_pkg, the block and ssnf_display_checker.
module tb_seven_segment_number_formatter;
  import ssnf_pkg::*;

  localparam int unsigned DIGITS      = DIGIT_COUNT_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_CMDS = 350;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  cmd_t cmd_i  = '0;
  logic busy;
  logic result_valid_o;
  res_t result_o;

  int mismatch_count;
  int pending_writes;
  int writes_checked;
  int cycle_count = 0;
  int dec_sent    = 0;
  int hex_sent    = 0;
  int bad_sent    = 0;

  always #4 clk_i = ~clk_i;

  seven_segment_number_formatter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  ssnf_display_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .cmd_i            (cmd_i),
    .busy             (busy),
    .result_valid_i   (result_valid_o),
    .result_i         (result_o),
    .mismatch_count_o (mismatch_count),
    .pending_writes_o (pending_writes),
    .writes_checked_o (writes_checked)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic kind, logic [3:0] first, logic [3:0] width,
                                    logic [31:0] number, logic [3:0] frac);
    cmd_t c;
    c.kind            = kind;
    c.first_position  = first;
    c.field_width     = width;
    c.number          = number;
    c.fraction_digits = frac;
    return c;
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 2000);
      2: v = $urandom_range(0, 99999999);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'd0;
          default: v = 32'd1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
    return v;
  endfunction

  function automatic cmd_t random_cmd(bit well_formed);
    cmd_t        c;
    int unsigned width;
    logic [63:0] raw_bits;
    if (well_formed) begin
      width = $urandom_range(1, DIGITS);
      c.kind            = ($urandom_range(0, 3) == 0);
      c.field_width     = 4'(width);
      c.first_position  = 4'($urandom_range(0, DIGITS - width));
      c.number          = random_number();
      c.fraction_digits = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, width));
    end else begin
      raw_bits = {$urandom, $urandom};
      c        = raw_bits[$bits(cmd_t)-1:0];
    end
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (c.field_width == 0 || c.first_position + c.field_width > DIGITS) bad_sent++;
    else if (c.kind) hex_sent++;
    else dec_sent++;
  endtask

  task automatic hold_idle(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_writes();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_writes != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(make_cmd(1'b0, 4'd0, 4'd0, 32'd123, 4'd0));
    send_cmd(make_cmd(1'b1, 4'd15, 4'd0, 32'hffff_ffff, 4'd15));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd8, 32'd0, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd8, 32'h7fff_ffff, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd8, 32'h8000_0000, 4'd3));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd8, 32'hffff_ffff, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd3, 4'd5, -32'sd1234, 4'd2));
    send_cmd(make_cmd(1'b0, 4'd7, 4'd1, -32'sd1, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd6, 4'd2, -32'sd12, 4'd1));
    send_cmd(make_cmd(1'b0, 4'd6, 4'd2, -32'sd52, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd4, 4'd4, -32'sd1999, 4'd3));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd8, 32'd5, 4'd3));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd8, 32'd12345, 4'd15));
    send_cmd(make_cmd(1'b0, 4'd4, 4'd4, 32'd123, 4'd1));
    send_cmd(make_cmd(1'b0, 4'd5, 4'd3, -32'sd10, 4'd1));
    send_cmd(make_cmd(1'b1, 4'd0, 4'd8, 32'hffff_ffff, 4'd0));
    send_cmd(make_cmd(1'b1, 4'd0, 4'd8, 32'hdead_beef, 4'd15));
    send_cmd(make_cmd(1'b1, 4'd5, 4'd3, 32'h1234_5678, 4'd2));
    send_cmd(make_cmd(1'b1, 4'd0, 4'd1, 32'h0000_000a, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd5, 4'd4, 32'd42, 4'd0));
    send_cmd(make_cmd(1'b1, 4'd7, 4'd9, 32'd42, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd15, 4'd15, 32'hffff_ffff, 4'd15));
    send_cmd(make_cmd(1'b0, 4'd8, 4'd1, 32'd7, 4'd0));
    send_cmd(make_cmd(1'b0, 4'd0, 4'd15, 32'd7, 4'd0));
    drain_writes();

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i == 60 || i == 260) drain_writes();
      if (!(i >= 120 && i < 240) && $urandom_range(0, 99) < 8)
        hold_idle($urandom_range(1, 40));
      send_cmd(random_cmd($urandom_range(0, 99) < 75));
    end

    drain_writes();
    repeat (60) @(posedge clk_i);
    $display("Covered %0d decimal, %0d hex and %0d empty or overflowing fields",
             dec_sent, hex_sent, bad_sent);
    $display("Compared %0d digit writes in %0d cycles", writes_checked, cycle_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
